FILE: rtl/lesf_pkg.sv
// Shared widths and register codes for the largest empty square finder.
`timescale 1ns / 1ps
package lesf_pkg;

    // Field widths fixed by the data format.
    localparam int CELL_W     = 8;
    localparam int SIZE_W     = 11;
    localparam int COORD_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int COLS_CFG_W = 11;

    // Largest size value; a larger square saturates here.
    localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 1'b1;

    // Register values after reset.
    localparam logic [CELL_W-1:0]     OBSTACLE_RST = 8'd111;
    localparam logic [COLS_CFG_W-1:0] COLUMNS_RST  = 11'd1024;

endpackage

FILE: rtl/largest_empty_square_finder_core.sv
// Top level of the largest empty square finder: counters, recurrence and best-square tracking.
`timescale 1ns / 1ps
// Usage
// Map cells enter on the slave stream, one byte a transfer in row-major order, with
// tlast high on the final cell of the map. A cell is blocked when its byte equals the
// obstacle register; the row length comes from the column register. Both are written
// on the configuration channel (index 0: obstacle byte, index 1: columns), which is
// always ready and must only be used while no map is in flight.
// One cell is taken every cycle unless the pipeline stalls. Each cell makes one read
// and one write of the line buffer RAM; the read is issued when the cell is taken and
// the write when the cell is in the recurrence stage, with a bypass when the next cell
// reads the entry being written. The single result (top row, left column, size of the
// largest free square, earliest top-left on a tie) appears on the master stream once
// the last cell has passed the best-square stage into the output register. A held
// result does not block input until another result has to pass it; then the whole
// pipeline stalls and input ready drops until the receiver takes the waiting result.
// Reset clears the counters, the best square and both streams and restores the
// registers; the line buffer needs no clearing, since every entry is written on the
// first row before it is read.
module largest_empty_square_finder_core #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream: tdata = cell_byte[7:0]; tlast = last_cell.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    // Master stream: tdata = top_row[9:0], left_column[19:10], square_size[30:20], zero[31].
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lesf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lesf_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = COL_W + 1;
    localparam int RCT_W = ROW_W + 1;
    localparam int RD_W  = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;
    localparam int CD_W  = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;

    // Configuration registers.
    logic [CELL_W-1:0]     r_obstacle;
    logic [COLS_CFG_W-1:0] r_columns;

    // Input stage: position counters.
    logic [COL_W-1:0] r_col_count;
    logic [ROW_W-1:0] r_row_count;
    logic             r_overflow;

    // Recurrence stage.
    logic             r1_valid;
    logic             r1_last;
    logic             r1_active;
    logic             r1_free;
    logic [COL_W-1:0] r1_col;
    logic [ROW_W-1:0] r1_row;
    logic              r_fwd_hit;
    logic [SIZE_W-1:0] r_fwd_size;
    logic [SIZE_W-1:0] r_left;
    logic [SIZE_W-1:0] r_diag;

    // Best-square stage.
    logic              r2_valid;
    logic              r2_last;
    logic              r2_active;
    logic [SIZE_W-1:0] r2_size;
    logic [COL_W-1:0]  r2_col;
    logic [ROW_W-1:0]  r2_row;
    logic [SIZE_W-1:0] r_best_size;
    logic [ROW_W-1:0]  r_best_row;
    logic [COL_W-1:0]  r_best_col;

    // Output register.
    logic              r_out_valid;
    logic [COORD_W-1:0] r_out_row;
    logic [COORD_W-1:0] r_out_col;
    logic [SIZE_W-1:0]  r_out_size;

    logic              w_adv;
    logic              w_accept;
    logic [CNT_W-1:0]  w_cols;
    logic [CNT_W-1:0]  w_col_next;
    logic [RCT_W-1:0]  w_row_next;
    logic [COL_W-1:0]  n_col_count;
    logic [ROW_W-1:0]  n_row_count;
    logic              n_overflow;
    logic [SIZE_W-1:0] w_mem_q;
    logic [SIZE_W-1:0] w_mem_q_raw;
    logic [SIZE_W-1:0] w_up;
    logic [SIZE_W-1:0] w_left;
    logic [SIZE_W-1:0] w_diag;
    logic [SIZE_W-1:0] w_min;
    logic [SIZE_W-1:0] w_size;
    logic              w_mem_we;
    logic [RD_W-1:0]   w_row_end;
    logic [CD_W-1:0]   w_col_end;
    logic [SIZE_W-1:0] n_best_size;
    logic [ROW_W-1:0]  n_best_row;
    logic [COL_W-1:0]  n_best_col;

    // The pipeline stalls only while a finished map waits for a full output register.
    assign w_adv           = !(r_out_valid && !i_m_axis_tready && r2_valid && r2_last);
    assign o_s_axis_tready = w_adv;
    assign w_accept        = i_s_axis_tvalid && w_adv;
    assign o_cfg_ready     = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle <= OBSTACLE_RST;
            r_columns  <= COLUMNS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_OBSTACLE: r_obstacle <= i_cfg_data[CELL_W-1:0];
                REG_COLUMNS:  r_columns  <= i_cfg_data[COLS_CFG_W-1:0];
                default:      r_columns  <= r_columns;
            endcase
        end
    end

    // Effective row length: zero acts as one, oversize acts as the maximum.
    always_comb begin
        if (r_columns == '0) begin
            w_cols = CNT_W'(1);
        end else if (32'(r_columns) > 32'(MAX_COLUMNS)) begin
            w_cols = CNT_W'(MAX_COLUMNS);
        end else begin
            w_cols = CNT_W'(r_columns);
        end
    end

    // Next position in the map.
    assign w_col_next = CNT_W'(r_col_count) + CNT_W'(1);
    assign w_row_next = RCT_W'(r_row_count) + RCT_W'(1);

    always_comb begin
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_overflow  = r_overflow;
        if (!r_overflow) begin
            if (w_col_next >= w_cols) begin
                n_col_count = '0;
                if (w_row_next >= RCT_W'(MAX_ROWS)) begin
                    n_overflow = 1'b1;
                end else begin
                    n_row_count = w_row_next[ROW_W-1:0];
                end
            end else begin
                n_col_count = w_col_next[COL_W-1:0];
            end
        end
        // A finished map starts the next one at the origin.
        if (i_s_axis_tlast) begin
            n_col_count = '0;
            n_row_count = '0;
            n_overflow  = 1'b0;
        end
    end

    // Line buffer output, or the size just written when the cell reads that entry.
    assign w_mem_q = r_fwd_hit ? r_fwd_size : w_mem_q_raw;

    // Recurrence: size = min(up, left, diagonal) + 1 for a free cell.
    always_comb begin
        w_up   = (r1_row != '0) ? w_mem_q : '0;
        w_left = (r1_col != '0) ? r_left : '0;
        w_diag = (r1_row != '0 && r1_col != '0) ? r_diag : '0;
        w_min  = (w_up < w_left) ? w_up : w_left;
        if (w_diag < w_min) begin
            w_min = w_diag;
        end
        if (!r1_free) begin
            w_size = '0;
        end else if (w_min == SIZE_SAT) begin
            w_size = SIZE_SAT;
        end else begin
            w_size = w_min + SIZE_W'(1);
        end
    end

    assign w_mem_we = w_adv && r1_valid && r1_active;

    lesf_line_buf #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r1_col),
        .i_wdata (w_size),
        .i_re    (w_accept),
        .i_raddr (r_col_count),
        .o_rdata (w_mem_q_raw)
    );

    // Best square: a strictly larger size replaces it, so the earliest wins a tie.
    assign w_row_end = RD_W'(r2_row) + RD_W'(1);
    assign w_col_end = CD_W'(r2_col) + CD_W'(1);

    always_comb begin
        n_best_size = r_best_size;
        n_best_row  = r_best_row;
        n_best_col  = r_best_col;
        if (r2_valid && r2_active && r2_size > r_best_size) begin
            n_best_size = r2_size;
            n_best_row  = (w_row_end >= RD_W'(r2_size)) ?
                          ROW_W'(w_row_end - RD_W'(r2_size)) : '0;
            n_best_col  = (w_col_end >= CD_W'(r2_size)) ?
                          COL_W'(w_col_end - CD_W'(r2_size)) : '0;
        end
    end

    // Control state of all stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_overflow  <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col_count <= n_col_count;
                r_row_count <= n_row_count;
                r_overflow  <= n_overflow;
            end
            if (w_adv) begin
                r1_valid  <= w_accept;
                r2_valid  <= r1_valid;
                // Bypass when the cell just taken reads the entry written this cycle.
                r_fwd_hit <= w_accept && w_mem_we && (r1_col == r_col_count);
                if (w_mem_we) begin
                    r_left <= w_size;
                    r_diag <= w_up;
                end
                if (r2_valid && r2_last) begin
                    r_best_size <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                end else begin
                    r_best_size <= n_best_size;
                    r_best_row  <= n_best_row;
                    r_best_col  <= n_best_col;
                end
            end
            if (w_adv && r2_valid && r2_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of all stages.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_accept) begin
                r1_last   <= i_s_axis_tlast;
                r1_active <= !r_overflow;
                r1_free   <= (i_s_axis_tdata != r_obstacle);
                r1_col    <= r_col_count;
                r1_row    <= r_row_count;
            end
            r_fwd_size <= w_size;
            r2_last    <= r1_last;
            r2_active  <= r1_active;
            r2_size    <= w_size;
            r2_col     <= r1_col;
            r2_row     <= r1_row;
            if (r2_valid && r2_last) begin
                r_out_row  <= COORD_W'(n_best_row);
                r_out_col  <= COORD_W'(n_best_col);
                r_out_size <= n_best_size;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_size, r_out_col, r_out_row};

    // A bypass only ever serves a cell that is in the recurrence stage.
    a_fwd_has_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r1_valid)
        else $error("line buffer bypass without a cell in the recurrence stage");

    // Within a map the best size never shrinks.
    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(r2_valid && r2_last)) |=> (r_best_size >= $past(r_best_size)))
        else $error("best square size decreased inside a map");

    // A new result follows a last cell leaving the best-square stage.
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r2_valid && r2_last && w_adv))
        else $error("result appeared without a last cell");

    // The column counter always addresses an existing line buffer entry.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (32'(r_col_count) < 32'(MAX_COLUMNS)))
        else $error("column counter beyond the line buffer");

endmodule

FILE: rtl/lesf_line_buf.sv
// Line buffer RAM: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module lesf_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [lesf_pkg::SIZE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [lesf_pkg::SIZE_W-1:0] o_rdata
);
    import lesf_pkg::*;

    logic [SIZE_W-1:0] r_mem [DEPTH];
    logic [SIZE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb_top.sv
// Testbench for the largest empty square finder: map streams checked against a square predictor.
`timescale 1ns / 1ps
module tb_top;
    import lesf_pkg::*;

    localparam int LINE_CELLS    = 1024;
    localparam int ROW_LIMIT     = 1024;
    localparam int RANDOM_CELLS  = 400;
    localparam int RANDOM_MAPS   = 25;
    localparam int SETTLE_CYCLES = 8;

    // One result of the block, in the order the fields are packed on the master stream.
    typedef struct packed {
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] left_column;
        logic [SIZE_W-1:0]  square_size;
    } square_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [CELL_W-1:0]     s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [31:0]           m_tdata;
    wire                   cfg_ready;

    // Predictor copy of the registers and of the per-map recurrence state.
    logic [CELL_W-1:0]     cfg_obstacle = OBSTACLE_RST;
    logic [COLS_CFG_W-1:0] cfg_columns  = COLUMNS_RST;
    logic [SIZE_W-1:0]     above_sizes [LINE_CELLS];
    logic [SIZE_W-1:0]     left_run;
    logic [SIZE_W-1:0]     diag_run;
    logic [SIZE_W-1:0]     best_side;
    int                    col_pos;
    int                    row_pos;
    int                    best_r;
    int                    best_c;
    bit                    rows_exhausted;
    square_t               expected_squares [$];

    // Stimulus and checking bookkeeping.
    int cells_sent     = 0;
    int burst_left     = 0;
    int mismatch_count = 0;
    bit tx_gaps        = 1'b0;
    bit rx_stalls      = 1'b0;
    int rx_run         = 0;
    bit rx_level       = 1'b1;

    largest_empty_square_finder_core #(
        .MAX_COLUMNS(LINE_CELLS),
        .MAX_ROWS   (ROW_LIMIT)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Effective row length: zero acts as one, anything above the line buffer is capped.
    function automatic int row_length();
        int len;
        len = int'(cfg_columns);
        if (len == 0) begin
            len = 1;
        end
        if (len > LINE_CELLS) begin
            len = LINE_CELLS;
        end
        return len;
    endfunction

    task automatic clear_map_state();
        left_run       = '0;
        diag_run       = '0;
        best_side      = '0;
        col_pos        = 0;
        row_pos        = 0;
        best_r         = 0;
        best_c         = 0;
        rows_exhausted = 1'b0;
    endtask

    // Runs the square-size recurrence on one accepted cell and queues the map result on tlast.
    task automatic predict_cell(input logic [CELL_W-1:0] cell_byte, input logic last);
        logic [SIZE_W-1:0] up;
        logic [SIZE_W-1:0] left;
        logic [SIZE_W-1:0] diag;
        logic [SIZE_W-1:0] side;
        square_t           sq;
        if (!rows_exhausted) begin
            up   = (row_pos > 0) ? above_sizes[col_pos] : '0;
            left = (col_pos > 0) ? left_run : '0;
            diag = (row_pos > 0 && col_pos > 0) ? diag_run : '0;
            if (cell_byte == cfg_obstacle) begin
                side = '0;
            end else begin
                side = up;
                if (left < side) begin
                    side = left;
                end
                if (diag < side) begin
                    side = diag;
                end
                if (side != SIZE_SAT) begin
                    side = side + 1'b1;
                end
            end
            diag_run             = up;
            left_run             = side;
            above_sizes[col_pos] = side;
            // Strictly greater keeps the earliest top-left on a tie.
            if (side > best_side) begin
                best_side = side;
                best_r    = row_pos + 1 - int'(side);
                best_c    = col_pos + 1 - int'(side);
                if (best_r < 0) begin
                    best_r = 0;
                end
                if (best_c < 0) begin
                    best_c = 0;
                end
            end
            if (col_pos + 1 >= row_length()) begin
                col_pos = 0;
                if (row_pos + 1 >= ROW_LIMIT) begin
                    rows_exhausted = 1'b1;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end
        end
        if (last) begin
            sq.top_row     = best_r[COORD_W-1:0];
            sq.left_column = best_c[COORD_W-1:0];
            sq.square_size = best_side;
            expected_squares.push_back(sq);
            clear_map_state();
        end
    endtask

    // Sends one cell, in bursts of random length separated by random gaps when gaps are enabled.
    task automatic send_cell(input logic [CELL_W-1:0] cell_byte, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= cell_byte;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        cells_sent++;
        predict_cell(cell_byte, last);
    endtask

    // Lowers the cell stream and waits until every queued result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expected_squares.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register once the block has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_OBSTACLE) begin
            cfg_obstacle = val[CELL_W-1:0];
        end else begin
            cfg_columns = val[COLS_CFG_W-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sends a map drawn as text: '#' is a blocked cell, anything else is free.
    task automatic send_text(input string map_text);
        for (int i = 0; i < map_text.len(); i++) begin
            send_cell((map_text[i] == "#") ? cfg_obstacle : ~cfg_obstacle,
                      i == map_text.len() - 1);
        end
    endtask

    // Reset registers: a short row of default obstacles with a few free cells.
    task automatic test_reset_defaults();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        for (int i = 0; i < 24; i++) begin
            send_cell((i % 5 == 3) ? ~cfg_obstacle : cfg_obstacle, i == 23);
        end
    endtask

    // Small hand-drawn maps: tie breaking, no free cell, early end, zero row length.
    task automatic test_directed_maps();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        write_reg(REG_OBSTACLE, '0);
        write_reg(REG_COLUMNS, CFG_DATA_W'(4));
        send_text({"..#.", "..#.", "##..", "##.."});
        send_text("####");
        send_text("#..");
        write_reg(REG_OBSTACLE, CFG_DATA_W'(8'hFF));
        write_reg(REG_COLUMNS, '0);
        send_text("#..");
    endtask

    // A row length beyond the line buffer wraps at 1024 cells.
    task automatic test_wide_rows();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        write_reg(REG_COLUMNS, CFG_DATA_W'(2047));
        for (int i = 0; i < LINE_CELLS + 2; i++) begin
            send_cell((i % LINE_CELLS < 2) ? ~cfg_obstacle : cfg_obstacle,
                      i == LINE_CELLS + 1);
        end
    endtask

    // Rows past the row limit must not touch the best square.
    task automatic test_row_overflow();
        int total;
        total     = ROW_LIMIT + 2;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b0;
        write_reg(REG_COLUMNS, CFG_DATA_W'(1));
        for (int i = 0; i < total; i++) begin
            send_cell((i >= ROW_LIMIT - 1) ? ~cfg_obstacle : cfg_obstacle, i == total - 1);
        end
    endtask

    // Random maps with random registers, obstacle densities and early ends.
    task automatic test_random_maps();
        int                    first_cell;
        int                    maps;
        int                    line_len;
        int                    cells;
        int                    density;
        bit                    noise;
        logic [CFG_DATA_W-1:0] new_value;
        logic [CELL_W-1:0]     cell_byte;
        first_cell = cells_sent;
        maps       = 0;
        while (cells_sent - first_cell < RANDOM_CELLS || maps < RANDOM_MAPS) begin
            if (maps == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: new_value = '0;
                    1: new_value = CFG_DATA_W'(8'hFF);
                    default: new_value = CFG_DATA_W'($urandom_range(0, 255));
                endcase
                write_reg(REG_OBSTACLE, new_value);
                if ($urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 4))
                        0: new_value = '0;
                        1: new_value = CFG_DATA_W'(1024);
                        2: new_value = CFG_DATA_W'(1025);
                        3: new_value = CFG_DATA_W'(2047);
                        default: new_value = CFG_DATA_W'($urandom_range(13, 2047));
                    endcase
                end else begin
                    new_value = CFG_DATA_W'($urandom_range(1, 12));
                end
                write_reg(REG_COLUMNS, new_value);
            end
            // Long rows get short maps; short rows get whole maps, sometimes cut short.
            line_len = row_length();
            if (line_len > 16) begin
                cells = $urandom_range(1, 40);
            end else begin
                cells = line_len * $urandom_range(1, 8);
                if ($urandom_range(0, 3) == 0) begin
                    cells -= $urandom_range(0, line_len - 1);
                end
            end
            case ($urandom_range(0, 5))
                0, 1: density = 0;
                2: density = 10;
                3: density = 30;
                4: density = 60;
                default: density = 100;
            endcase
            noise     = ($urandom_range(0, 7) == 0);
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < cells; i++) begin
                if (noise) begin
                    cell_byte = CELL_W'($urandom_range(0, 255));
                end else if ($urandom_range(1, 100) <= density) begin
                    cell_byte = cfg_obstacle;
                end else begin
                    cell_byte = CELL_W'($urandom_range(0, 255));
                    if (cell_byte == cfg_obstacle) begin
                        cell_byte ^= 8'h01;
                    end
                end
                send_cell(cell_byte, i == cells - 1);
            end
            maps++;
        end
    endtask

    // Result receiver: ready follows runs of random length when stalls are enabled.
    always @(negedge clk) begin
        if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_run   = $urandom_range(1, 10);
                rx_level = ($urandom_range(0, 2) != 0);
            end
            rx_run--;
            m_tready <= rx_level;
        end
    end

    // Compares each result transfer with the oldest predicted square.
    always @(posedge clk) begin : check_result
        square_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_squares.size() == 0) begin
                $error("result transfer with no square expected: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_squares.pop_front();
                if (m_tdata[9:0] !== want.top_row) begin
                    $error("top_row mismatch: expected %0d, actual %0d",
                           want.top_row, m_tdata[9:0]);
                    mismatch_count++;
                end
                if (m_tdata[19:10] !== want.left_column) begin
                    $error("left_column mismatch: expected %0d, actual %0d",
                           want.left_column, m_tdata[19:10]);
                    mismatch_count++;
                end
                if (m_tdata[30:20] !== want.square_size) begin
                    $error("square_size mismatch: expected %0d, actual %0d",
                           want.square_size, m_tdata[30:20]);
                    mismatch_count++;
                end
                if (m_tdata[31] !== 1'b0) begin
                    $error("padding mismatch: expected 0, actual %b", m_tdata[31]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        clear_map_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_maps();
        test_wide_rows();
        test_row_overflow();
        test_random_maps();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
